// File: hw/rtl/pidsi_pkg.sv
// shared types, constants and widths for the shaped-integral pid controller
package pidsi_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LIM_W  = 31;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned MUL_V_W = 49;
  localparam int unsigned TERM_W = 64;
  localparam int unsigned DIV_N_W = 48;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned ADDR_W = 5;

  localparam logic [LIM_W-1:0] VAR_SPEED_SPAN_DEFAULT      = '0;
  localparam logic [LIM_W-1:0] VAR_SPEED_FULL_BAND_DEFAULT = '0;
  localparam bit               DERIV_ON_MEASUREMENT_DEFAULT = 1'b0;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [2:0] REG_KP  = 3'd0;
  localparam logic [2:0] REG_KI  = 3'd1;
  localparam logic [2:0] REG_KD  = 3'd2;
  localparam logic [2:0] REG_KF  = 3'd3;
  localparam logic [2:0] REG_ILIM = 3'd4;
  localparam logic [2:0] REG_OLIM = 3'd5;
  localparam logic [2:0] REG_DZ  = 3'd6;
  localparam logic [2:0] REG_SEP = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_RATIO,
    S_RDIV,
    S_IM_GO,
    S_IM_W,
    S_SEP,
    S_BDIV,
    S_I_GO,
    S_I_W,
    S_D_GO,
    S_D_W,
    S_F_GO,
    S_F_W,
    S_P_GO,
    S_P_W,
    S_OUT
  } state_t;

endpackage

// File: hw/rtl/pidsi_mul.sv
// bit-serial signed q16.16 multiplier, one multiplier bit per cycle
module pidsi_mul
  import pidsi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DATA_W-1:0]  g,
  input  logic signed [MUL_V_W-1:0] v,
  output logic                      done,
  output logic signed [TERM_W-1:0]  result
);

  logic [DATA_W-1:0]  ug;
  logic [ACC_W-1:0]   uv;
  logic               neg;
  logic [ACC_W-1:0]   hi;
  logic [DATA_W-1:0]  lo;
  logic [4:0]         cnt;
  logic               busy;
  logic [ACC_W:0]     psum;
  logic [MUL_V_W-1:0] v_abs;
  logic [TERM_W-1:0]  mag;
  logic [TERM_W-1:0]  mag_cap;

  assign v_abs = v[MUL_V_W-1] ? (~v + 1'b1) : v;
  assign psum  = {1'b0, hi} + (ug[0] ? {1'b0, uv} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ug  <= g[DATA_W-1] ? (~g + 1'b1) : g;
      uv  <= v_abs[ACC_W-1:0];
      neg <= g[DATA_W-1] ^ v[MUL_V_W-1];
      hi  <= '0;
      lo  <= '0;
    end else if (busy) begin
      ug <= ug >> 1;
      hi <= psum[ACC_W:1];
      lo <= {psum[0], lo[DATA_W-1:1]};
    end
  end

  // product is {hi, lo}; drop 16 fraction bits, cap magnitude at 2^60
  assign mag     = {hi, lo[DATA_W-1:16]};
  assign mag_cap = (mag > 64'h1000_0000_0000_0000) ? 64'h1000_0000_0000_0000 : mag;
  assign result  = neg ? -$signed(mag_cap) : $signed(mag_cap);

endmodule

// File: hw/rtl/pidsi_div.sv
// restoring unsigned divider, one quotient bit per cycle
module pidsi_div
  import pidsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] n,
  input  logic [DATA_W-1:0]  d,
  output logic               done,
  output logic [DIV_N_W-1:0] q
);

  logic [DIV_N_W-1:0] nsh;
  logic [DATA_W-1:0]  dv;
  logic [DATA_W-1:0]  rem;
  logic [5:0]         cnt;
  logic               busy;
  logic [DATA_W:0]    trial;
  logic               fits;

  assign trial = {rem, nsh[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= n;
      dv  <= d;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      rem <= fits ? 32'(trial - {1'b0, dv}) : trial[DATA_W-1:0];
      q   <= {q[DIV_N_W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/pid_controller_shaped_integral.sv
// top level of the shaped-integral pid controller with sequencer and config registers
//
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-------------------------------------
// input    | in_valid  | in_stall  | target, measurement, clear
// output   | out_valid | out_stall | drive, output_clamped
// config   | apb write | (pready)  | paddr[4:2] selects register, pwdata
//
// a transaction is accepted in S_IDLE and then runs through the shared serial units:
// up to five serial multiplies (integral multiply skipped when separation trips),
// up to two serial divides (speed ratio, windup bound) and the sequencing states;
// the result is registered in S_OUT
// reset clears the sequencer, config registers, integral and history at once
// the next input transaction is taken while a finished result waits on out_stall
module pid_controller_shaped_integral
  import pidsi_pkg::*;
#(
  parameter logic [LIM_W-1:0] VAR_SPEED_SPAN       = VAR_SPEED_SPAN_DEFAULT,
  parameter logic [LIM_W-1:0] VAR_SPEED_FULL_BAND  = VAR_SPEED_FULL_BAND_DEFAULT,
  parameter bit               DERIV_ON_MEASUREMENT = DERIV_ON_MEASUREMENT_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] target,
  input  logic signed [DATA_W-1:0] measurement,
  input  logic                     clear,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] drive,
  output logic                     output_clamped,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  state_t state, state_next;

  // configuration registers
  logic signed [DATA_W-1:0] kp, ki, kd, kf;
  logic [LIM_W-1:0]         ilim, olim, dz, sep;

  // loop state and per-transaction working registers
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] prev_err, prev_tgt, prev_meas;
  logic signed [DATA_W-1:0] tgt, meas, err;
  logic [DATA_W-1:0]        aerr;
  logic [RATIO_W-1:0]       ratio;
  logic signed [TERM_W-1:0] sum;

  // shared serial units
  logic                      mul_start, mul_done;
  logic signed [DATA_W-1:0]  mul_g;
  logic signed [MUL_V_W-1:0] mul_v;
  logic signed [TERM_W-1:0]  mul_res;
  logic                      div_start, div_done;
  logic [DIV_N_W-1:0]        div_n, div_q;
  logic [DATA_W-1:0]         div_d;

  logic in_acc, cfg_wr, out_load;

  // error path
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] err_sat;
  logic [DATA_W-1:0]        aerr_raw;
  logic                     in_dz;

  // speed ratio decision
  logic [DATA_W:0]  spb;
  logic [DATA_W:0]  rnum;
  logic             ratio_full, ratio_div;

  logic             sep_hit, bound_on;
  logic signed [DATA_W:0]  d_diff, f_diff;
  logic signed [ACC_W+1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat, bound_s;

  logic signed [TERM_W-1:0] lim_hi, lim_lo, drv64;
  logic                     over, under;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_acc = in_valid && !in_stall;

  // ---------------- serial units ----------------
  pidsi_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .g      (mul_g),
    .v      (mul_v),
    .done   (mul_done),
    .result (mul_res)
  );

  pidsi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0; ki <= '0; kd <= '0; kf <= '0;
      ilim <= '0; olim <= '0; dz <= '0; sep <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_KP:   kp   <= pwdata;
        REG_KI:   ki   <= pwdata;
        REG_KD:   kd   <= pwdata;
        REG_KF:   kf   <= pwdata;
        REG_ILIM: ilim <= pwdata[LIM_W-1:0];
        REG_OLIM: olim <= pwdata[LIM_W-1:0];
        REG_DZ:   dz   <= pwdata[LIM_W-1:0];
        REG_SEP:  sep  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KP:   prdata = kp;
      REG_KI:   prdata = ki;
      REG_KD:   prdata = kd;
      REG_KF:   prdata = kf;
      REG_ILIM: prdata = {1'b0, ilim};
      REG_OLIM: prdata = {1'b0, olim};
      REG_DZ:   prdata = {1'b0, dz};
      REG_SEP:  prdata = {1'b0, sep};
      default:  prdata = '0;
    endcase
  end

  // ---------------- datapath combinational ----------------
  // saturated error, magnitude and dead zone
  assign diff     = {tgt[DATA_W-1], tgt} - {meas[DATA_W-1], meas};
  assign err_sat  = (diff[DATA_W] != diff[DATA_W-1]) ?
                    (diff[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff) : diff[DATA_W-1:0];
  assign aerr_raw = err_sat[DATA_W-1] ? (~err_sat + 1'b1) : err_sat;
  assign in_dz    = aerr_raw < {1'b0, dz};

  // ratio is 1.0 inside the full band, falls linearly across the span
  assign spb        = {2'b00, VAR_SPEED_SPAN} + {2'b00, VAR_SPEED_FULL_BAND};
  assign rnum       = spb - {1'b0, aerr};
  assign ratio_full = ((VAR_SPEED_SPAN == '0) && (VAR_SPEED_FULL_BAND == '0)) ||
                      (aerr <= {1'b0, VAR_SPEED_FULL_BAND});
  assign ratio_div  = !ratio_full && ({1'b0, aerr} < spb) && (VAR_SPEED_SPAN != '0);

  assign sep_hit  = (sep != '0) && (aerr >= {1'b0, sep});
  assign bound_on = (ilim != '0) && (ki != '0);

  assign d_diff = DERIV_ON_MEASUREMENT ?
                  ({prev_meas[DATA_W-1], prev_meas} - {meas[DATA_W-1], meas}) :
                  ({err[DATA_W-1], err} - {prev_err[DATA_W-1], prev_err});
  assign f_diff = {tgt[DATA_W-1], tgt} - {prev_tgt[DATA_W-1], prev_tgt};

  // accumulator update saturates to 48 bits
  assign acc_sum = {{2{acc[ACC_W-1]}}, acc} + mul_res[ACC_W+1:0];
  assign acc_sat = (acc_sum[ACC_W+1:ACC_W-1] == 3'b000 ||
                    acc_sum[ACC_W+1:ACC_W-1] == 3'b111) ? acc_sum[ACC_W-1:0] :
                   (acc_sum[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}} :
                                       {1'b0, {(ACC_W-1){1'b1}}});
  assign bound_s = $signed({1'b0, div_q[ACC_W-2:0]});

  // output clamp
  assign lim_hi = (olim != '0) ? $signed({{(TERM_W-LIM_W){1'b0}}, olim})
                               : 64'sh0000_0000_7fff_ffff;
  assign lim_lo = -lim_hi - ((olim != '0) ? 64'sd0 : 64'sd1);
  assign over   = sum > lim_hi;
  assign under  = sum < lim_lo;
  assign drv64  = over ? lim_hi : (under ? lim_lo : sum);

  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // ---------------- sequencer next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_ERR;
      S_ERR:   state_next = S_RATIO;
      S_RATIO: state_next = ratio_div ? S_RDIV : S_IM_GO;
      S_RDIV:  if (div_done) state_next = S_IM_GO;
      S_IM_GO: state_next = S_IM_W;
      S_IM_W:  if (mul_done) state_next = S_SEP;
      S_SEP: begin
        if (sep_hit) state_next = S_D_GO;
        else if (bound_on) state_next = S_BDIV;
        else state_next = S_I_GO;
      end
      S_BDIV:  if (div_done) state_next = S_I_GO;
      S_I_GO:  state_next = S_I_W;
      S_I_W:   if (mul_done) state_next = S_D_GO;
      S_D_GO:  state_next = S_D_W;
      S_D_W:   if (mul_done) state_next = S_F_GO;
      S_F_GO:  state_next = S_F_W;
      S_F_W:   if (mul_done) state_next = S_P_GO;
      S_P_GO:  state_next = S_P_W;
      S_P_W:   if (mul_done) state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    in_stall  = (state != S_IDLE);
    mul_start = 1'b0;
    mul_g     = kp;
    mul_v     = {{(MUL_V_W-DATA_W){err[DATA_W-1]}}, err};
    div_start = 1'b0;
    div_n     = {1'b0, rnum[LIM_W-1:0], 16'h0000};
    div_d     = {1'b0, VAR_SPEED_SPAN};
    case (state)
      S_RATIO: div_start = ratio_div;
      S_IM_GO: begin
        mul_start = 1'b1;
        mul_g     = {{(DATA_W-RATIO_W){1'b0}}, ratio};
      end
      S_SEP: begin
        div_start = !sep_hit && bound_on;
        div_n     = {1'b0, ilim, 16'h0000};
        div_d     = ki[DATA_W-1] ? (~ki + 1'b1) : ki;
      end
      S_I_GO: begin
        mul_start = 1'b1;
        mul_g     = ki;
        mul_v     = {acc[ACC_W-1], acc};
      end
      S_D_GO: begin
        mul_start = 1'b1;
        mul_g     = kd;
        mul_v     = {{(MUL_V_W-DATA_W-1){d_diff[DATA_W]}}, d_diff};
      end
      S_F_GO: begin
        mul_start = 1'b1;
        mul_g     = kf;
        mul_v     = {{(MUL_V_W-DATA_W-1){f_diff[DATA_W]}}, f_diff};
      end
      S_P_GO:  mul_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // ---------------- loop state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      prev_err  <= '0;
      prev_tgt  <= '0;
      prev_meas <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_acc && clear) begin
          acc       <= '0;
          prev_err  <= '0;
          prev_tgt  <= '0;
          prev_meas <= '0;
        end
        S_IM_W: if (mul_done) acc <= acc_sat;
        S_SEP:  if (sep_hit) acc <= '0;
        S_BDIV: if (div_done) begin
          if (acc > bound_s) acc <= bound_s;
          else if (acc < -bound_s) acc <= -bound_s;
        end
        S_OUT: if (out_load) begin
          prev_err  <= err;
          prev_tgt  <= tgt;
          prev_meas <= meas;
        end
        default: ;
      endcase
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt  <= target;
      meas <= measurement;
    end
    case (state)
      S_ERR: begin
        err  <= in_dz ? '0 : err_sat;
        aerr <= in_dz ? '0 : aerr_raw;
        sum  <= '0;
      end
      S_RATIO: if (!ratio_div) ratio <= ratio_full ? RATIO_ONE : '0;
      S_RDIV:  if (div_done) ratio <= div_q[RATIO_W-1:0];
      S_I_W, S_D_W, S_F_W, S_P_W: if (mul_done) sum <= sum + mul_res;
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive          <= drv64[DATA_W-1:0];
      output_clamped <= over || under;
    end
  end

  // ---------------- assertions ----------------
  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_IM_W || state == S_I_W || state == S_D_W ||
                  state == S_F_W || state == S_P_W))
    else $error("multiplier finished outside a wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_RDIV || state == S_BDIV))
    else $error("divider finished outside a wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_ERR && in_stall))
    else $error("accepted transaction did not start the sequence");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule
